@@ hdl/mct_pkg.sv @@
`default_nettype none
package mct_pkg;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_START    = 3'd1,
        ACT_CONTINUE = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_UPDATE   = 3'd4,
        ACT_CLEAR    = 3'd5,
        ACT_RSVD6    = 3'd6,
        ACT_RSVD7    = 3'd7
    } action_t;

    localparam logic [1:0] REG_SOURCE  = 2'd0;
    localparam logic [1:0] REG_BPB     = 2'd1;
    localparam logic [1:0] REG_TICK_US = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    localparam logic [31:0] MIN_INTERVAL_US = 32'd2000;
    localparam logic [31:0] MAX_INTERVAL_US = 32'd250000;

    // datapath operation requested by the controller
    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOAD    = 4'd1,
        OP_APPLY   = 4'd2,
        OP_UPDATE  = 4'd3,
        OP_DIVSTEP = 4'd4,
        OP_TICK    = 4'd5,
        OP_FINISH  = 4'd6
    } op_t;

    typedef struct packed {
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic ticks_left;
        logic need_catchup;
    } status_t;

endpackage
`default_nettype wire

@@ hdl/midi_clock_tracker_core.sv @@
`default_nettype none
// MIDI clock tracker, 24 ticks per quarter note.
// Input channel (in_valid/in_stall) carries one item: action and now_us.
// Output channel (out_valid/out_stall) returns one result item per input item:
// position, latched beat/bar edges, running flag, interval estimate, ticks fired.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), written idle.
// Most actions pass through a load step and an apply step. A catch-up time update
// in internal mode then runs a 32-bit bit-serial divide of the elapsed time by the
// tick period, fires up to TICKS_PER_BEAT*CATCHUP_BEATS ticks one by one through
// the shared tick update, closes the tick loop and loads the output register.
// Throughput: one item at a time; the next item is taken once the current one
// has left for the output register.
// Reset clears the tracker state and loads the register defaults; no result is pending.
// When the receiver stalls, the result holds in the output register and the
// block stops after loading the next item until the register frees.
module midi_clock_tracker_core
    import mct_pkg::*;
#(
    parameter int TICKS_PER_BEAT = 24,
    parameter int CATCHUP_BEATS  = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [21:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] now_us,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      tick_position,
    output logic             beat_edge,
    output logic             bar_edge,
    output logic             is_running,
    output logic [17:0]      interval_estimate_us,
    output logic [6:0]       ticks_fired
);

    cmd_t    cmd;
    status_t status;

    mct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mct_dp #(
        .TICKS_PER_BEAT (TICKS_PER_BEAT),
        .CATCHUP_BEATS  (CATCHUP_BEATS)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .action               (action),
        .now_us               (now_us),
        .cmd                  (cmd),
        .status               (status),
        .tick_position        (tick_position),
        .beat_edge            (beat_edge),
        .bar_edge             (bar_edge),
        .is_running           (is_running),
        .interval_estimate_us (interval_estimate_us),
        .ticks_fired          (ticks_fired)
    );

endmodule
`default_nettype wire

@@ hdl/mct_ctrl.sv @@
`default_nettype none
module mct_ctrl
    import mct_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_APPLY  = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_TICK   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign out_valid = out_valid_reg;
    // a result may still wait in the output register while the next item loads
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op     = OP_APPLY;
                    state_next = ST_IDLE;
                    if (status.need_catchup)
                    begin
                        cmd.op     = OP_UPDATE;
                        state_next = ST_DIV;
                    end
                    else
                        out_valid_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIVSTEP;
                if (status.div_done)
                    state_next = ST_TICK;
            end
            ST_TICK:
            begin
                if (status.ticks_left)
                    cmd.op = OP_TICK;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/mct_dp.sv @@
`default_nettype none
module mct_dp
    import mct_pkg::*;
#(
    parameter int TICKS_PER_BEAT = 24,
    parameter int CATCHUP_BEATS  = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [21:0] cfg_data,
    input  wire logic [2:0]  action,
    input  wire logic [31:0] now_us,
    input  wire cmd_t        cmd,
    output status_t          status,
    output logic [31:0]      tick_position,
    output logic             beat_edge,
    output logic             bar_edge,
    output logic             is_running,
    output logic [17:0]      interval_estimate_us,
    output logic [6:0]       ticks_fired
);

    localparam int CAP = TICKS_PER_BEAT * CATCHUP_BEATS;
    localparam int CW  = $clog2(CAP + 1);
    localparam int TW  = $clog2(TICKS_PER_BEAT);
    localparam int TPBW = (TW < 1) ? 1 : TW;

    logic        src_reg;
    logic [4:0]  bpb_reg;
    logic [16:0] per_reg;
    logic [21:0] tmo_reg;
    logic [31:0] cnt_reg;
    logic        run_reg, beat_reg, bar_reg;
    logic [31:0] lts_reg, lus_reg;
    logic [17:0] avg_reg;
    logic [TPBW-1:0] bph_reg;   // tick_count mod TICKS_PER_BEAT
    logic [3:0]  bmod_reg [16]; // beats since start mod (k+1), one lane per bar length
    logic [2:0]  act_reg;
    logic [31:0] now_reg;
    // divider
    logic [31:0] rem_reg, quo_reg;
    logic [5:0]  dstep_reg;
    logic [CW-1:0] left_reg, fired_reg;
    logic [31:0] po_cnt_reg;
    logic        po_beat_reg, po_bar_reg, po_run_reg;
    logic [17:0] po_avg_reg;
    logic [6:0]  po_fired_reg;

    logic [3:0] bar_lane;
    assign bar_lane = 4'(bpb_reg - 5'd1);

    assign status.need_catchup = (act_reg == ACT_UPDATE) && src_reg && run_reg
                                 && (lts_reg != 32'd0);
    assign status.div_done     = (dstep_reg == 6'd31);
    assign status.ticks_left   = (left_reg != '0);

    // one tick on the phase counters and the interval filter
    logic [31:0] tk_iv;
    logic [20:0] tk_acc;
    logic [17:0] tk_avg;
    logic        tk_beat, tk_bar;
    logic        tk_wrap;
    logic [TPBW-1:0] tk_bph;
    logic [3:0]  tk_bmod [16];
    logic [31:0] tk_stamp;

    assign tk_stamp = (cmd.op == OP_TICK) ? (lts_reg + {15'd0, per_reg}) : lus_reg;

    always_comb
    begin
        tk_iv  = tk_stamp - lts_reg;
        tk_acc = ({3'd0, avg_reg} << 3) - {3'd0, avg_reg} + tk_iv[20:0];
        tk_avg = avg_reg;
        if (lts_reg != 32'd0 && tk_iv >= MIN_INTERVAL_US && tk_iv <= MAX_INTERVAL_US)
            tk_avg = (avg_reg == 18'd0) ? tk_iv[17:0] : tk_acc[20:3];
        // a count wrapping to zero lands on a beat and a bar
        tk_wrap  = (cnt_reg == 32'hFFFF_FFFF);
        tk_bph   = (tk_wrap || 32'(bph_reg) == TICKS_PER_BEAT - 1) ? '0 : bph_reg + 1'b1;
        tk_beat  = (tk_bph == '0);
        for (int k = 0; k < 16; k++)
        begin
            if (tk_wrap)
                tk_bmod[k] = 4'd0;
            else if (tk_beat && bmod_reg[k] == 4'(k))
                tk_bmod[k] = 4'd0;
            else if (tk_beat)
                tk_bmod[k] = bmod_reg[k] + 4'd1;
            else
                tk_bmod[k] = bmod_reg[k];
        end
        tk_bar   = tk_beat && (tk_bmod[bar_lane] == 4'd0);
    end

    logic [32:0] dsub;
    assign dsub = {rem_reg[31:0], quo_reg[31]} - {16'd0, per_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg   <= 1'b0;
            bpb_reg   <= 5'd4;
            per_reg   <= 17'd20833;
            tmo_reg   <= 22'd500000;
            cnt_reg   <= '0;
            run_reg   <= 1'b0;
            beat_reg  <= 1'b0;
            bar_reg   <= 1'b0;
            lts_reg   <= '0;
            lus_reg   <= '0;
            avg_reg   <= '0;
            bph_reg   <= '0;
            bmod_reg  <= '{default: 4'd0};
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SOURCE:
                    begin
                        if (cfg_data[0] != src_reg)
                        begin
                            src_reg <= cfg_data[0];
                            lts_reg <= '0;
                            avg_reg <= '0;
                            run_reg <= cfg_data[0];
                        end
                    end
                    REG_BPB:
                    begin
                        // the bar test reads the beat lane of the new bar length
                        bpb_reg <= (cfg_data[4:0] == 5'd0) ? 5'd1 :
                                   (cfg_data[4:0] > 5'd16) ? 5'd16 : cfg_data[4:0];
                    end
                    REG_TICK_US:
                        per_reg <= (cfg_data[16:0] < 17'd8333) ? 17'd8333 :
                                   (cfg_data[16:0] > 17'd125000) ? 17'd125000 :
                                   cfg_data[16:0];
                    REG_TIMEOUT:
                        tmo_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_APPLY, OP_UPDATE:
                begin
                    unique case (act_reg)
                        ACT_TICK:
                        begin
                            if (!src_reg && run_reg)
                            begin
                                avg_reg   <= tk_avg;
                                lts_reg   <= lus_reg;
                                cnt_reg   <= cnt_reg + 32'd1;
                                bph_reg   <= tk_bph;
                                bmod_reg  <= tk_bmod;
                                if (tk_beat) beat_reg <= 1'b1;
                                if (tk_bar)  bar_reg  <= 1'b1;
                            end
                        end
                        ACT_START:
                        begin
                            cnt_reg   <= '0;
                            bph_reg   <= '0;
                            bmod_reg  <= '{default: 4'd0};
                            run_reg   <= 1'b1;
                            beat_reg  <= 1'b1;
                            bar_reg   <= 1'b1;
                            lts_reg   <= '0;
                        end
                        ACT_CONTINUE:
                        begin
                            run_reg <= 1'b1;
                            lts_reg <= '0;
                        end
                        ACT_STOP: run_reg <= 1'b0;
                        ACT_UPDATE:
                        begin
                            lus_reg <= now_reg;
                            if (src_reg)
                            begin
                                if (run_reg && lts_reg == 32'd0)
                                    lts_reg <= now_reg;
                            end
                            else if (run_reg && lts_reg != 32'd0
                                     && (now_reg - lts_reg) > {10'd0, tmo_reg})
                                run_reg <= 1'b0;
                        end
                        ACT_CLEAR:
                        begin
                            beat_reg <= 1'b0;
                            bar_reg  <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_TICK:
                begin
                    lts_reg   <= tk_stamp;
                    cnt_reg   <= cnt_reg + 32'd1;
                    bph_reg   <= tk_bph;
                    bmod_reg  <= tk_bmod;
                    if (tk_beat) beat_reg <= 1'b1;
                    if (tk_bar)  bar_reg  <= 1'b1;
                end
                OP_FINISH: avg_reg <= {1'b0, per_reg};
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            act_reg <= action;
            now_reg <= now_us;
        end
        unique case (cmd.op)
            OP_UPDATE:
            begin
                rem_reg   <= '0;
                quo_reg   <= now_reg - lts_reg;
                dstep_reg <= '0;
                fired_reg <= '0;
            end
            OP_DIVSTEP:
            begin
                dstep_reg <= dstep_reg + 6'd1;
                if (!dsub[32])
                begin
                    rem_reg <= dsub[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                if (status.div_done)
                begin
                    if ((!dsub[32] ? {quo_reg[30:0], 1'b1} : {quo_reg[30:0], 1'b0})
                        > 32'(CAP))
                    begin
                        left_reg  <= CW'(CAP);
                        fired_reg <= CW'(CAP);
                    end
                    else
                    begin
                        left_reg  <= !dsub[32] ? CW'({quo_reg[30:0], 1'b1})
                                               : CW'({quo_reg[30:0], 1'b0});
                        fired_reg <= !dsub[32] ? CW'({quo_reg[30:0], 1'b1})
                                               : CW'({quo_reg[30:0], 1'b0});
                    end
                end
            end
            OP_TICK: left_reg <= left_reg - 1'b1;
            default: ;
        endcase
        if (cmd.op == OP_APPLY)
        begin
            po_cnt_reg   <= (act_reg == ACT_START) ? 32'd0 :
                            (act_reg == ACT_TICK && !src_reg && run_reg) ? cnt_reg + 32'd1
                            : cnt_reg;
            po_beat_reg  <= (act_reg == ACT_START) ? 1'b1 :
                            (act_reg == ACT_TICK && !src_reg && run_reg) ? (beat_reg | tk_beat)
                            : beat_reg;
            po_bar_reg   <= (act_reg == ACT_START) ? 1'b1 :
                            (act_reg == ACT_TICK && !src_reg && run_reg) ? (bar_reg | tk_bar)
                            : bar_reg;
            po_run_reg   <= (act_reg == ACT_START || act_reg == ACT_CONTINUE) ? 1'b1 :
                            (act_reg == ACT_STOP) ? 1'b0 :
                            (act_reg == ACT_UPDATE && !src_reg && run_reg
                             && lts_reg != 32'd0
                             && (now_reg - lts_reg) > {10'd0, tmo_reg}) ? 1'b0 : run_reg;
            po_avg_reg   <= (act_reg == ACT_TICK && !src_reg && run_reg) ? tk_avg : avg_reg;
            po_fired_reg <= '0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            po_cnt_reg   <= cnt_reg;
            po_beat_reg  <= beat_reg;
            po_bar_reg   <= bar_reg;
            po_run_reg   <= run_reg;
            po_avg_reg   <= {1'b0, per_reg};
            po_fired_reg <= 7'(fired_reg);
        end
    end

    assign tick_position        = po_cnt_reg;
    assign beat_edge            = po_beat_reg;
    assign bar_edge             = po_bar_reg;
    assign is_running           = po_run_reg;
    assign interval_estimate_us = po_avg_reg;
    assign ticks_fired          = po_fired_reg;

endmodule
`default_nettype wire

@@ tb/tb_midi_clock_tracker_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_midi_clock_tracker_core
    import mct_pkg::*;
();

    localparam int PER_BEAT = 24;
    localparam int CATCHUP  = 4;
    localparam int CYCLE_LIMIT = 900000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [21:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [31:0] now_us;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] tick_position;
    logic        beat_edge;
    logic        bar_edge;
    logic        is_running;
    logic [17:0] interval_estimate_us;
    logic [6:0]  ticks_fired;

    midi_clock_tracker_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .action(action), .now_us(now_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .tick_position(tick_position), .beat_edge(beat_edge), .bar_edge(bar_edge),
        .is_running(is_running), .interval_estimate_us(interval_estimate_us),
        .ticks_fired(ticks_fired)
    );

    typedef struct packed {
        logic [31:0] position;
        logic        beat;
        logic        bar;
        logic        running;
        logic [17:0] estimate;
        logic [6:0]  fired;
    } clock_report_t;

    // tracker copy
    logic        src_int;
    logic [4:0]  bpb;
    logic [31:0] tick_us;
    logic [31:0] stall_us;
    logic [31:0] pos;
    logic        run_f, beat_f, bar_f;
    logic [31:0] tick_stamp, upd_stamp;
    logic [31:0] avg;

    clock_report_t pending_reports[$];
    int  errors;
    int  cycles;
    bit  idle_free;
    bit  hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic tracker_reset();
        src_int = 1'b0; bpb = 5'd4; tick_us = 20833; stall_us = 500000;
        pos = 0; run_f = 1'b0; beat_f = 1'b0; bar_f = 1'b0;
        tick_stamp = 0; upd_stamp = 0; avg = 0;
    endtask

    task automatic tracker_write(input logic [1:0] idx, input logic [21:0] val);
        logic [31:0] t;
        case (idx)
            REG_SOURCE:
            begin
                if (val[0] != src_int)
                begin
                    src_int = val[0];
                    tick_stamp = 0;
                    avg = 0;
                    run_f = val[0];
                end
            end
            REG_BPB:
            begin
                t = {27'd0, val[4:0]};
                bpb = (t < 1) ? 5'd1 : (t > 16) ? 5'd16 : t[4:0];
            end
            REG_TICK_US:
            begin
                t = {15'd0, val[16:0]};
                tick_us = (t < 8333) ? 8333 : (t > 125000) ? 125000 : t;
            end
            default: stall_us = {10'd0, val};
        endcase
    endtask

    function automatic void advance_tick(input logic [31:0] stamp);
        logic [31:0] iv;
        logic [63:0] acc;
        if (tick_stamp != 0)
        begin
            iv = stamp - tick_stamp;
            if (iv >= MIN_INTERVAL_US && iv <= MAX_INTERVAL_US)
            begin
                if (avg == 0)
                    avg = iv;
                else
                begin
                    acc = 64'(avg) * 7 + iv;
                    avg = 32'(acc / 8);
                end
            end
        end
        tick_stamp = stamp;
        pos = pos + 1;
        if (pos % PER_BEAT == 0)
        begin
            beat_f = 1'b1;
            if (pos % (PER_BEAT * bpb) == 0)
                bar_f = 1'b1;
        end
    endfunction

    function automatic clock_report_t track_item(input logic [2:0] act,
                                                 input logic [31:0] now);
        clock_report_t r;
        logic [31:0] n;
        n = 0;
        case (action_t'(act))
            ACT_TICK: if (!src_int && run_f) advance_tick(upd_stamp);
            ACT_START:
            begin
                pos = 0; run_f = 1'b1; beat_f = 1'b1; bar_f = 1'b1; tick_stamp = 0;
            end
            ACT_CONTINUE:
            begin
                run_f = 1'b1; tick_stamp = 0;
            end
            ACT_STOP: run_f = 1'b0;
            ACT_UPDATE:
            begin
                upd_stamp = now;
                if (src_int)
                begin
                    if (run_f)
                    begin
                        if (tick_stamp == 0)
                            tick_stamp = now;
                        else
                        begin
                            n = (now - tick_stamp) / tick_us;
                            if (n > PER_BEAT * CATCHUP) n = PER_BEAT * CATCHUP;
                            for (int i = 0; i < n; i++)
                                advance_tick(tick_stamp + tick_us);
                            avg = tick_us;
                        end
                    end
                end
                else if (run_f && tick_stamp != 0 && (now - tick_stamp) > stall_us)
                    run_f = 1'b0;
            end
            default: ;
        endcase
        r.position = pos; r.beat = beat_f; r.bar = bar_f; r.running = run_f;
        r.estimate = avg[17:0]; r.fired = n[6:0];
        if (act == ACT_CLEAR)
        begin
            beat_f = 1'b0; bar_f = 1'b0;
        end
        return r;
    endfunction

    // receiver
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else
                out_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 28);
        end
    end

    always @(posedge clk)
    begin
        clock_report_t e;
        if (out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_reports.pop_front();
                if (tick_position !== e.position)
                begin
                    $error("tick_position exp %0d got %0d", e.position, tick_position);
                    errors++;
                end
                if (beat_edge !== e.beat)
                begin
                    $error("beat_edge exp %0d got %0d", e.beat, beat_edge);
                    errors++;
                end
                if (bar_edge !== e.bar)
                begin
                    $error("bar_edge exp %0d got %0d", e.bar, bar_edge);
                    errors++;
                end
                if (is_running !== e.running)
                begin
                    $error("is_running exp %0d got %0d", e.running, is_running);
                    errors++;
                end
                if (interval_estimate_us !== e.estimate)
                begin
                    $error("interval_estimate_us exp %0d got %0d", e.estimate,
                           interval_estimate_us);
                    errors++;
                end
                if (ticks_fired !== e.fired)
                begin
                    $error("ticks_fired exp %0d got %0d", e.fired, ticks_fired);
                    errors++;
                end
            end
        end
    end

    // offer one item; valid stays up until the next call or a drain drops it
    task automatic send_item(input logic [2:0] act, input logic [31:0] now);
        clock_report_t r;
        while (!idle_free && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        now_us   <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = track_item(act, now);
        pending_reports.push_back(r);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
        drain();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker_write(idx, val);
    endtask

    typedef struct {
        logic [2:0]  act;
        logic [31:0] now;
        bit          typed;
        logic [31:0] pos;
        logic        run;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{ACT_RSVD6,    32'd0,          1, 32'd0, 1'b0},
        '{ACT_TICK,     32'd0,          1, 32'd0, 1'b0},
        '{ACT_START,    32'd0,          1, 32'd0, 1'b1},
        '{ACT_CLEAR,    32'd0,          1, 32'd0, 1'b1},
        '{ACT_UPDATE,   32'd1000,       0, 0, 0},
        '{ACT_TICK,     32'd0,          0, 0, 0},
        '{ACT_UPDATE,   32'd1500,       0, 0, 0},
        '{ACT_TICK,     32'd0,          0, 0, 0},
        '{ACT_UPDATE,   32'd21500,      0, 0, 0},
        '{ACT_TICK,     32'd0,          0, 0, 0},
        '{ACT_UPDATE,   32'd271501,     0, 0, 0},
        '{ACT_TICK,     32'd0,          0, 0, 0},
        '{ACT_UPDATE,   32'hFFFF_FFFF,  0, 0, 0},
        '{ACT_STOP,     32'hFFFF_FFFF,  0, 0, 0},
        '{ACT_TICK,     32'd0,          0, 0, 0},
        '{ACT_CONTINUE, 32'd0,          0, 0, 0},
        '{ACT_UPDATE,   32'd5,          0, 0, 0},
        '{ACT_TICK,     32'd0,          0, 0, 0},
        '{ACT_UPDATE,   32'd9000000,    0, 0, 0},
        '{ACT_RSVD7,    32'h5555_AAAA,  0, 0, 0},
        '{ACT_CLEAR,    32'd0,          0, 0, 0}
    };

    task automatic run_random(input int count);
        logic [31:0] t;
        int k;
        t = $urandom_range(1, 1000);
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 40)
                send_item(ACT_TICK, $urandom);
            else if (k < 75)
            begin
                // mostly plausible time steps, some wild jumps
                t = ($urandom_range(9) == 0) ? $urandom : t + $urandom_range(0, 300000);
                send_item(ACT_UPDATE, t);
            end
            else if (k < 82) send_item(ACT_CLEAR, $urandom);
            else if (k < 86) send_item(ACT_START, $urandom);
            else if (k < 90) send_item(ACT_CONTINUE, $urandom);
            else if (k < 94) send_item(ACT_STOP, $urandom);
            else send_item(3'($urandom_range(6, 7)), $urandom);
        end
    endtask

    initial
    begin
        clock_report_t r;
        cycles = 0; errors = 0; idle_free = 1'b0; hold_off = 1'b0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = REG_SOURCE; cfg_data = '0;
        in_valid = 1'b0; action = ACT_TICK; now_us = '0;
        tracker_reset();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i].act, directed[i].now);
            if (directed[i].typed)
            begin
                r = pending_reports[$];
                if (r.position !== directed[i].pos || r.running !== directed[i].run)
                begin
                    $error("tick_position/is_running exp %0d/%0d got %0d/%0d",
                           directed[i].pos, directed[i].run, r.position, r.running);
                    errors++;
                end
            end
        end

        // external mode, extremes of timeout and bar length
        write_reg(REG_BPB, 22'd0);
        write_reg(REG_TIMEOUT, 22'd1);
        send_item(ACT_START, 0);
        send_item(ACT_UPDATE, 32'd10);
        send_item(ACT_TICK, 0);
        send_item(ACT_UPDATE, 32'd12);
        write_reg(REG_TIMEOUT, 22'h3F_FFFF);
        write_reg(REG_BPB, 22'h1F);
        run_random(90);

        // long hold-off so the block backs up its input
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            run_random(10);
        join

        // internal mode, shortest and longest periods
        write_reg(REG_SOURCE, 22'd1);
        write_reg(REG_TICK_US, 22'd0);
        send_item(ACT_UPDATE, 32'd100);
        send_item(ACT_UPDATE, 32'd100 + 8333 * 96 + 5000000);
        send_item(ACT_CLEAR, 0);
        write_reg(REG_TICK_US, 22'h3F_FFFF);
        write_reg(REG_BPB, 22'd1);
        idle_free = 1'b1;
        run_random(110);
        idle_free = 1'b0;
        write_reg(REG_TICK_US, 22'd20833);
        write_reg(REG_SOURCE, 22'd1);
        run_random(80);

        // back to external
        write_reg(REG_SOURCE, 22'd0);
        write_reg(REG_BPB, 22'd4);
        write_reg(REG_TIMEOUT, 22'd500000);
        send_item(ACT_START, 0);
        run_random(110);

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ midi_clock_tracker_core.f @@
hdl/mct_pkg.sv
hdl/mct_ctrl.sv
hdl/mct_dp.sv
hdl/midi_clock_tracker_core.sv
tb/tb_midi_clock_tracker_core.sv
